@@ rtl/core/tcpq_pkg.sv @@
// shared types and constants for the two-class priority queue
// no dependencies; used by tcpq_cell and two_class_priority_queue
package tcpq_pkg;

	localparam int TCPQ_CAPACITY   = 16;
	localparam int TCPQ_IDENT_BITS = 16;
	localparam int IDENT_W         = 16;
	localparam int LENGTH_W        = 5;

	typedef enum logic [1:0] {
		ACT_INSERT   = 2'd0,
		ACT_SERVE    = 2'd1,
		ACT_WITHDRAW = 2'd2,
		ACT_LOOKUP   = 2'd3
	} tcpq_action_t;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} tcpq_state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_REMOVE
	} tcpq_cmd_kind_t;

	typedef struct packed {
		tcpq_cmd_kind_t kind;
		logic           pref;
	} tcpq_cmd_t;

endpackage

@@ rtl/core/tcpq_cell.sv @@
// one slot of the queue row: holds an id and its class, matches a key,
// and shifts toward or away from the head on broadcast commands; uses tcpq_pkg
module tcpq_cell import tcpq_pkg::*; #(
	parameter int INDEX      = 0,
	parameter int IDENT_BITS = TCPQ_IDENT_BITS,
	parameter int CNT_W      = 5,
	parameter int IDX_W      = 4
) (
	input  logic                  clk,
	input  tcpq_cmd_t             cmd,
	input  logic [IDX_W-1:0]      pos,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [IDENT_BITS-1:0] key,
	input  logic [IDENT_BITS-1:0] lo_ident,
	input  logic                  lo_pref,
	input  logic [IDENT_BITS-1:0] hi_ident,
	input  logic                  hi_pref,
	output logic [IDENT_BITS-1:0] ident_q,
	output logic                  pref_q,
	output logic                  match
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

	// only occupied slots take part in the search
	assign match = (MY_CNT < cnt) && (ident_q == key);

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_INSERT: begin
				if (MY_IDX == pos) begin
					ident_q <= key;
					pref_q  <= cmd.pref;
				end else if (MY_IDX > pos) begin
					ident_q <= lo_ident;
					pref_q  <= lo_pref;
				end
			end
			CMD_REMOVE: begin
				if (MY_IDX >= pos) begin
					ident_q <= hi_ident;
					pref_q  <= hi_pref;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/two_class_priority_queue.sv @@
// top level of the two-class priority queue: control, search encoder and
// output register around a row of tcpq_cell slots; uses tcpq_pkg
//
// A bounded queue of up to CAPACITY unique ids in two classes: every preferred
// entry stands ahead of every ordinary one, and each class keeps arrival order.
// Each transfer in carries one action (insert, serve head, withdraw id, look up
// id) and yields exactly one transfer out with ok, the served id, the entry
// class and the queue length after the action. In the accept cycle every
// slot compares its id with the key in parallel and the hit position is
// encoded and registered; in the apply step (ST_APPLY) the whole row of
// slots shifts one place (open a gap for insert, close one for serve or
// withdraw) and the result is loaded into the output register. The input is
// stalled during the apply step, which stretches for as long as the output
// register still holds an earlier result that has not been taken. Slot
// contents need no reset; only the counts, the control state and the output
// valid are cleared.
module two_class_priority_queue import tcpq_pkg::*; #(
	parameter int CAPACITY   = TCPQ_CAPACITY,
	parameter int IDENT_BITS = TCPQ_IDENT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [IDENT_W-1:0]  ident,
	input  logic                preferred,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                ok,
	output logic [IDENT_W-1:0]  served_ident,
	output logic                entry_preferred,
	output logic [LENGTH_W-1:0] length
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int EXT_W = IDENT_BITS + IDENT_W;
	localparam int LEN_X = CNT_W + LENGTH_W;

	tcpq_state_t state_q, state_d;

	// counts of occupied and preferred slots
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] pcnt_q, pcnt_d;

	// item captured at accept, plus the registered search result
	tcpq_action_t          act_q;
	logic [IDENT_BITS-1:0] key_q;
	logic                  pref_q;
	logic                  found_q;
	logic                  cls_q;
	logic [IDX_W-1:0]      pos_q;

	// output register
	logic                 out_valid_q;
	logic                 ok_q;
	logic [IDENT_W-1:0]   served_q;
	logic                 cls_out_q;
	logic [LENGTH_W-1:0]  len_q;

	// row of slots
	logic [IDENT_BITS-1:0] cell_ident [CAPACITY];
	logic                  cell_pref  [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;

	logic [EXT_W-1:0]      ident_x;
	logic [IDENT_BITS-1:0] key_sel;
	logic                  accept;
	logic                  go;
	logic                  found_d;
	logic                  cls_d;
	logic [IDX_W-1:0]      pos_d;

	tcpq_cmd_t             cmd;
	logic [IDX_W-1:0]      cmd_pos;
	logic                  ok_d;
	logic [IDENT_W-1:0]    served_d;
	logic                  cls_out_d;
	logic [EXT_W-1:0]      head_x;
	logic [LEN_X-1:0]      len_x;
	logic                  full;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// the apply step waits only when the output register is still occupied
	assign go       = (state_q == ST_APPLY) && (!out_valid_q || !out_stall);

	// key for the search: in the accept cycle it comes straight from the port
	assign ident_x = EXT_W'(ident);
	assign key_sel = (state_q == ST_IDLE) ? ident_x[IDENT_BITS-1:0] : key_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [IDENT_BITS-1:0] lo_id, hi_id;
			logic                  lo_pf, hi_pf;
			if (gi == 0) begin : g_head
				assign lo_id = '0;
				assign lo_pf = 1'b0;
			end else begin : g_body
				assign lo_id = cell_ident[gi-1];
				assign lo_pf = cell_pref[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign hi_id = '0;
				assign hi_pf = 1'b0;
			end else begin : g_inner
				assign hi_id = cell_ident[gi+1];
				assign hi_pf = cell_pref[gi+1];
			end
			tcpq_cell #(
				.INDEX      (gi),
				.IDENT_BITS (IDENT_BITS),
				.CNT_W      (CNT_W),
				.IDX_W      (IDX_W)
			) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.pos      (cmd_pos),
				.cnt      (cnt_q),
				.key      (key_sel),
				.lo_ident (lo_id),
				.lo_pref  (lo_pf),
				.hi_ident (hi_id),
				.hi_pref  (hi_pf),
				.ident_q  (cell_ident[gi]),
				.pref_q   (cell_pref[gi]),
				.match    (cell_match[gi])
			);
		end
	endgenerate

	// ids are unique, so at most one slot hits; plain or-encode its index
	always_comb begin
		found_d = |cell_match;
		cls_d   = 1'b0;
		pos_d   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_match[i]) begin
				pos_d = pos_d | IDX_W'(i);
				cls_d = cls_d | cell_pref[i];
			end
		end
	end

	// apply step: decide the row command, new counts and the result
	always_comb begin
		full      = (cnt_q == CNT_W'(CAPACITY));
		head_x    = EXT_W'(cell_ident[0]);
		cmd.kind  = CMD_NONE;
		cmd.pref  = pref_q;
		cmd_pos   = pos_q;
		ok_d      = 1'b0;
		served_d  = '0;
		cls_out_d = 1'b0;
		cnt_d     = cnt_q;
		pcnt_d    = pcnt_q;
		case (act_q)
			ACT_INSERT: begin
				if (!found_q && !full) begin
					ok_d     = 1'b1;
					cmd.kind = CMD_INSERT;
					cmd_pos  = pref_q ? pcnt_q[IDX_W-1:0] : cnt_q[IDX_W-1:0];
					cnt_d    = cnt_q + CNT_W'(1);
					if (pref_q) begin
						pcnt_d = pcnt_q + CNT_W'(1);
					end
				end
			end
			ACT_SERVE: begin
				if (cnt_q != '0) begin
					ok_d      = 1'b1;
					served_d  = head_x[IDENT_W-1:0];
					cls_out_d = cell_pref[0];
					cmd.kind  = CMD_REMOVE;
					cmd_pos   = '0;
					cnt_d     = cnt_q - CNT_W'(1);
					if (cell_pref[0] && pcnt_q != '0) begin
						pcnt_d = pcnt_q - CNT_W'(1);
					end
				end
			end
			ACT_WITHDRAW: begin
				if (found_q) begin
					ok_d     = 1'b1;
					cmd.kind = CMD_REMOVE;
					cnt_d    = cnt_q - CNT_W'(1);
					if (cls_q && pcnt_q != '0) begin
						pcnt_d = pcnt_q - CNT_W'(1);
					end
				end
			end
			ACT_LOOKUP: begin
				ok_d      = found_q;
				cls_out_d = found_q && cls_q;
			end
			default: begin
			end
		endcase
		// row and counts move only when the result can be registered
		if (!go) begin
			cmd.kind = CMD_NONE;
		end
		len_x = LEN_X'(cnt_d);
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				cnt_q       <= cnt_d;
				pcnt_q      <= pcnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and search result captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= tcpq_action_t'(action);
			key_q   <= ident_x[IDENT_BITS-1:0];
			pref_q  <= preferred;
			found_q <= found_d;
			cls_q   <= cls_d;
			pos_q   <= pos_d;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go) begin
			ok_q      <= ok_d;
			served_q  <= served_d;
			cls_out_q <= cls_out_d;
			len_q     <= len_x[LENGTH_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = ok_q;
	assign served_ident    = served_q;
	assign entry_preferred = cls_out_q;
	assign length          = len_q;

endmodule

@@ test/tcpq_queue_checker.sv @@
// watches both channels of the two-class priority queue, keeps its own copy of the
// queue, and compares every result transfer against the predicted one
// depends on tcpq_pkg for widths, capacity and action codes
module tcpq_queue_checker import tcpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          action,
	input  logic [IDENT_W-1:0]  ident,
	input  logic                preferred,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                ok,
	input  logic [IDENT_W-1:0]  served_ident,
	input  logic                entry_preferred,
	input  logic [LENGTH_W-1:0] length,
	output int                  fail_count,
	output int                  open_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [IDENT_W-1:0] IDENT_MASK = IDENT_W'((64'd1 << TCPQ_IDENT_BITS) - 1);

	typedef struct packed {
		logic                ok;
		logic [IDENT_W-1:0]  served;
		logic                cls;
		logic [LENGTH_W-1:0] len;
	} queue_result_t;

	// shadow queue: slot 0 is the head, preferred entries occupy 0..pref_len-1
	logic [IDENT_W-1:0] shadow_ident [TCPQ_CAPACITY];
	logic               shadow_pref  [TCPQ_CAPACITY];
	int                 queue_len = 0;
	int                 pref_len = 0;
	int                 mismatches = 0;
	queue_result_t      pending_results [$];
	queue_result_t      want;

	function automatic int find_ident(logic [IDENT_W-1:0] id);
		for (int i = 0; i < queue_len; i++)
			if (shadow_ident[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void remove_at(int pos);
		if (shadow_pref[pos])
			pref_len--;
		for (int i = pos; i + 1 < queue_len; i++) begin
			shadow_ident[i] = shadow_ident[i + 1];
			shadow_pref[i]  = shadow_pref[i + 1];
		end
		queue_len--;
	endfunction

	function automatic queue_result_t apply_queue_op(tcpq_action_t act,
			logic [IDENT_W-1:0] id, logic pref);
		queue_result_t r;
		int            pos;
		int            slot;
		r = '0;
		pos = find_ident(id);
		case (act)
			ACT_INSERT: begin
				if (queue_len < TCPQ_CAPACITY && pos < 0) begin
					slot = pref ? pref_len : queue_len;
					for (int i = queue_len; i > slot; i--) begin
						shadow_ident[i] = shadow_ident[i - 1];
						shadow_pref[i]  = shadow_pref[i - 1];
					end
					shadow_ident[slot] = id;
					shadow_pref[slot]  = pref;
					queue_len++;
					if (pref)
						pref_len++;
					r.ok = 1'b1;
				end
			end
			ACT_SERVE: begin
				if (queue_len > 0) begin
					r.ok     = 1'b1;
					r.served = shadow_ident[0];
					r.cls    = shadow_pref[0];
					remove_at(0);
				end
			end
			ACT_WITHDRAW: begin
				if (pos >= 0) begin
					r.ok = 1'b1;
					remove_at(pos);
				end
			end
			default: begin
				if (pos >= 0) begin
					r.ok  = 1'b1;
					r.cls = shadow_pref[pos];
				end
			end
		endcase
		r.len = LENGTH_W'(queue_len);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] expv, logic [31:0] got);
		if (got !== expv) begin
			$error("%s: expected %0d, got %0d", name, expv, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_len = 0;
			pref_len = 0;
			mismatches = 0;
			pending_results.delete();
			open_results <= 0;
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				pending_results.push_back(apply_queue_op(tcpq_action_t'(action),
					ident & IDENT_MASK, preferred));
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no operation outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("ok", 32'(want.ok), 32'(ok));
					check_field("served_ident", 32'(want.served), 32'(served_ident));
					check_field("entry_preferred", 32'(want.cls), 32'(entry_preferred));
					check_field("length", 32'(want.len), 32'(length));
				end
			end
			open_results <= pending_results.size();
			fail_count <= mismatches;
		end
	end

endmodule

@@ test/two_class_priority_queue_tb.sv @@
// stimulus and verdict for the two-class priority queue: directed corner cases,
// then random fill, drain and mixed phases under bursty input and output stalls
// depends on tcpq_pkg, two_class_priority_queue and tcpq_queue_checker
module two_class_priority_queue_tb import tcpq_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1750;
	localparam int POOL_SIZE    = 24;
	localparam int IDLE_LIMIT   = 2000;

	typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;
	typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          action = ACT_INSERT;
	logic [IDENT_W-1:0]  ident = '0;
	logic                preferred = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                ok;
	logic [IDENT_W-1:0]  served_ident;
	logic                entry_preferred;
	logic [LENGTH_W-1:0] length;
	int                  fail_count;
	int                  open_results;

	// ids mostly come from a small pool so that duplicates, hits and a full
	// queue are common; slots 0 and 1 hold the all-zero and all-one ids
	logic [IDENT_W-1:0]  id_pool [POOL_SIZE];
	int                  burst_left = 0;
	int                  idle_cycles = 0;
	rx_mode_t            rx_mode = RX_FREE;
	int                  rx_left = 0;

	two_class_priority_queue uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.ident           (ident),
		.preferred       (preferred),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.served_ident    (served_ident),
		.entry_preferred (entry_preferred),
		.length          (length)
	);

	tcpq_queue_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.ident           (ident),
		.preferred       (preferred),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.served_ident    (served_ident),
		.entry_preferred (entry_preferred),
		.length          (length),
		.fail_count      (fail_count),
		.open_results    (open_results)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: switches between free-running, choppy and mostly-stalled stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(32, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE:   out_stall <= 1'b0;
			RX_CHOPPY: out_stall <= ($urandom_range(0, 1) == 1);
			default:   out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// watchdog: any transfer on either side resets the idle count
	wire moved = (in_valid && !in_stall) || (out_valid && !out_stall);

	always @(posedge clk) begin
		if (moved)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [IDENT_W-1:0] pick_ident();
		if ($urandom_range(0, 99) < 85)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		return IDENT_W'($urandom_range(0, 65535));
	endfunction

	// one operation transfer; a new burst may start with a gap where valid drops,
	// otherwise valid stays high straight into the next item
	task automatic push_op(input tcpq_action_t act, input logic [IDENT_W-1:0] id,
			input logic pref);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		action    <= act;
		ident     <= id;
		preferred <= pref;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		phase_kind_t  kind;
		tcpq_action_t act;
		int           span;
		int           roll;
		int           sent;
		bit           first_phase;

		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = IDENT_W'($urandom_range(0, 65535));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue misses first
		push_op(ACT_SERVE, 16'h0000, 1'b1);
		push_op(ACT_LOOKUP, 16'h1234, 1'b0);
		push_op(ACT_WITHDRAW, 16'hA5A5, 1'b1);
		// class ordering: a preferred entry jumps ahead of the ordinary one
		push_op(ACT_INSERT, 16'h0000, 1'b0);
		push_op(ACT_INSERT, 16'hFFFF, 1'b1);
		// duplicate id is refused even with a different class
		push_op(ACT_INSERT, 16'h0000, 1'b1);
		push_op(ACT_INSERT, 16'h5A5A, 1'b1);
		push_op(ACT_INSERT, 16'hA5A5, 1'b0);
		push_op(ACT_LOOKUP, 16'hFFFF, 1'b0);
		push_op(ACT_LOOKUP, 16'h0000, 1'b1);
		// withdraw the last preferred entry, then insert across the boundary again
		push_op(ACT_WITHDRAW, 16'h5A5A, 1'b0);
		push_op(ACT_INSERT, 16'h1234, 1'b1);
		// withdraw the first entry of the ordinary class
		push_op(ACT_WITHDRAW, 16'h0000, 1'b1);
		push_op(ACT_SERVE, 16'hFFFF, 1'b0);
		push_op(ACT_SERVE, 16'h0000, 1'b1);
		push_op(ACT_SERVE, 16'hFFFF, 1'b1);
		push_op(ACT_SERVE, 16'h0000, 1'b0);
		push_op(ACT_WITHDRAW, 16'h0000, 1'b0);
		push_op(ACT_LOOKUP, 16'hFFFF, 1'b1);

		// random phases; the first one fills the queue up to capacity and beyond
		sent = 0;
		first_phase = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			kind = first_phase ? PH_FILL : phase_kind_t'($urandom_range(0, 2));
			span = first_phase ? 40 : $urandom_range(20, 80);
			first_phase = 1'b0;
			repeat (span) begin
				roll = $urandom_range(0, 99);
				case (kind)
					PH_FILL: begin
						act = (roll < 85) ? ACT_INSERT : (roll < 95) ? ACT_LOOKUP : ACT_SERVE;
					end
					PH_DRAIN: begin
						act = (roll < 45) ? ACT_SERVE : (roll < 80) ? ACT_WITHDRAW :
							(roll < 95) ? ACT_LOOKUP : ACT_INSERT;
					end
					default: begin
						act = tcpq_action_t'($urandom_range(0, 3));
					end
				endcase
				push_op(act, pick_ident(), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
		in_valid <= 1'b0;

		// drain the outstanding results, then let the block sit idle before the verdict
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
